### rtl/core/mpq_pkg.sv
// shared constants, codes and controller/datapath interface types for the priority queue
`default_nettype none

package mpq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TAG_W    = 16;
    localparam int KEY_W    = 16;
    localparam int ST_W     = 2;

    localparam logic [ST_W-1:0]  ST_OK    = 2'd0;
    localparam logic [ST_W-1:0]  ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0]  ST_FULL  = 2'd2;

    localparam logic [TAG_W-1:0] TAG_NONE = 16'hFFFF;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    typedef struct packed {
        logic            load;          // capture the request on a start transfer
        logic            ins_write;     // store the captured pair at the tail
        logic            scan_start;    // begin minimum scan at the newest entry
        logic            scan_step;     // compare one entry, move to the older one
        logic            shift_start;   // begin closing the gap at the removed slot
        logic            shift_step;    // move one entry down by one slot
        logic            extract_done;  // drop one entry from the count
        logic            emit;          // present a result next cycle
        logic            emit_tag;      // result carries the found tag
        logic [ST_W-1:0] emit_status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_insert;
        logic full;
        logic empty;
        logic ptr_zero;     // scan has reached the oldest entry
        logic best_last;    // removed entry is the newest, nothing to shift
        logic shift_last;   // this shift moves the newest entry
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/mpq_datapath.sv
// entry storage, minimum scan and gap-closing shift of the priority queue
`default_nettype none

module mpq_datapath
    import mpq_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_action,
    input  wire  [TAG_W-1:0] i_item_tag,
    input  wire  [KEY_W-1:0] i_item_key,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic             o_valid,
    output logic [TAG_W-1:0] o_out_tag,
    output logic [ST_W-1:0]  o_status
);

    logic [TAG_W-1:0] tag_mem [CAPACITY];
    logic [KEY_W-1:0] key_mem [CAPACITY];

    logic             r_action;
    logic [TAG_W-1:0] r_in_tag;
    logic [KEY_W-1:0] r_in_key;
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] n_ptr;
    logic [TAG_W-1:0] r_rd_tag;
    logic [KEY_W-1:0] r_rd_key;
    logic             r_have;
    logic [IDX_W-1:0] r_best_idx;
    logic [KEY_W-1:0] r_best_key;
    logic [TAG_W-1:0] r_best_tag;
    logic             r_out_valid;
    logic [TAG_W-1:0] r_out_tag;
    logic [ST_W-1:0]  r_out_status;

    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [TAG_W-1:0] wr_tag;
    logic [KEY_W-1:0] wr_key;
    logic             take_new;
    logic [IDX_W-1:0] tail_idx;

    assign tail_idx = IDX_W'(r_fill - CNT_W'(1));

    assign o_sts.is_insert  = (r_action == ACT_INSERT);
    assign o_sts.full       = (r_fill == CNT_W'(CAPACITY));
    assign o_sts.empty      = (r_fill == '0);
    assign o_sts.ptr_zero   = (r_ptr == '0);
    assign o_sts.best_last  = ((CNT_W'(r_best_idx) + CNT_W'(1)) == r_fill);
    assign o_sts.shift_last = ((CNT_W'(r_ptr) + CNT_W'(2)) == r_fill);

    // newest-to-oldest scan, strict compare keeps the newest of equal keys
    assign take_new = !r_have || ($signed(r_rd_key) < $signed(r_best_key));

    always_comb begin
        rd_addr = '0;
        n_ptr   = r_ptr;
        if (i_cmd.scan_start) begin
            rd_addr = tail_idx;
            n_ptr   = tail_idx;
        end else if (i_cmd.scan_step && !o_sts.ptr_zero) begin
            rd_addr = r_ptr - IDX_W'(1);
            n_ptr   = r_ptr - IDX_W'(1);
        end else if (i_cmd.shift_start) begin
            rd_addr = r_best_idx + IDX_W'(1);
            n_ptr   = r_best_idx;
        end else if (i_cmd.shift_step && !o_sts.shift_last) begin
            rd_addr = r_ptr + IDX_W'(2);
            n_ptr   = r_ptr + IDX_W'(1);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_tag  = r_rd_tag;
        wr_key  = r_rd_key;
        if (i_cmd.ins_write) begin
            wr_en   = 1'b1;
            wr_addr = r_fill[IDX_W-1:0];
            wr_tag  = r_in_tag;
            wr_key  = r_in_key;
        end else if (i_cmd.shift_step) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            tag_mem[wr_addr] <= wr_tag;
            key_mem[wr_addr] <= wr_key;
        end
        r_rd_tag <= tag_mem[rd_addr];
        r_rd_key <= key_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_action <= i_action;
            r_in_tag <= i_item_tag;
            r_in_key <= i_item_key;
        end
        if (i_cmd.scan_step && take_new) begin
            r_best_idx <= r_ptr;
            r_best_key <= r_rd_key;
            r_best_tag <= r_rd_tag;
        end
        if (i_cmd.emit) begin
            r_out_tag    <= i_cmd.emit_tag ? r_best_tag : TAG_NONE;
            r_out_status <= i_cmd.emit_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
            if (i_cmd.scan_start) begin
                r_have <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_have <= 1'b1;
            end
            if (i_cmd.ins_write) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (i_cmd.extract_done) begin
                r_fill <= r_fill - CNT_W'(1);
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_out_tag = r_out_tag;
    assign o_status  = r_out_status;

endmodule

`default_nettype wire

### rtl/core/mpq_ctrl.sv
// sequencing state machine of the priority queue
`default_nettype none

module mpq_ctrl
    import mpq_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_SHSTART = 3'd3;
    localparam logic [2:0] S_SHIFT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_insert) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.emit_status = ST_FULL;
                    end else begin
                        o_cmd.ins_write   = 1'b1;
                        o_cmd.emit_status = ST_OK;
                    end
                    n_state = S_IDLE;
                end else if (i_sts.empty) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_EMPTY;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.ptr_zero) begin
                    n_state = S_SHSTART;
                end
            end
            S_SHSTART: begin
                if (i_sts.best_last) begin
                    o_cmd.extract_done = 1'b1;
                    o_cmd.emit         = 1'b1;
                    o_cmd.emit_tag     = 1'b1;
                    o_cmd.emit_status  = ST_OK;
                    n_state            = S_IDLE;
                end else begin
                    o_cmd.shift_start = 1'b1;
                    n_state           = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_sts.shift_last) begin
                    o_cmd.extract_done = 1'b1;
                    o_cmd.emit         = 1'b1;
                    o_cmd.emit_tag     = 1'b1;
                    o_cmd.emit_status  = ST_OK;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### rtl/core/min_priority_queue.sv
// top level of the bounded min-priority queue of (tag, key) pairs
//
//   channel   ports                                       transfer
//   request   start, i_action, i_item_tag, i_item_key     start && !busy at a clock edge
//   result    o_valid, o_out_tag, o_status                o_valid high for one cycle
//
// insert, or extract from an empty queue: the result is registered from the execute state
// extract: execute, a scan step per entry from newest to oldest, then a shift step per
// entry newer than the minimum; one read port of the entry store serves scan and shift
// busy stays high until the result is registered; a new request may transfer while the
// result is shown. synchronous active-low reset empties the queue
// the receiver cannot stall, so a result is never held back
`default_nettype none

module min_priority_queue
    import mpq_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  wire              i_action,
    input  wire  [TAG_W-1:0] i_item_tag,
    input  wire  [KEY_W-1:0] i_item_key,
    output logic             o_valid,
    output logic [TAG_W-1:0] o_out_tag,
    output logic [ST_W-1:0]  o_status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    mpq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_action   (i_action),
        .i_item_tag (i_item_tag),
        .i_item_key (i_item_key),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .o_out_tag  (o_out_tag),
        .o_status   (o_status)
    );

endmodule

`default_nettype wire

### test/min_priority_queue_tb.sv
// self-checking testbench for the bounded min-priority queue: random insert/extract traffic
`default_nettype none

module min_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int RANDOM_ITEMS = 650;

    typedef struct {
        logic             act;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        int               gap;
        bit               drain;
    } t_queue_request;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [ST_W-1:0]  status;
    } t_queue_result;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             i_action   = ACT_INSERT;
    logic [TAG_W-1:0] i_item_tag = '0;
    logic [KEY_W-1:0] i_item_key = '0;
    logic             busy;
    logic             o_valid;
    logic [TAG_W-1:0] o_out_tag;
    logic [ST_W-1:0]  o_status;

    t_queue_request request_queue[$];
    t_queue_result  expected_results[$];

    // shadow copy of the queue contents, oldest entry in slot 0
    logic [TAG_W-1:0] shadow_tag[CAPACITY];
    logic [KEY_W-1:0] shadow_key[CAPACITY];
    int               shadow_fill = 0;

    int  error_count = 0;
    int  cycle_count = 0;
    int  idle_cycles = 0;
    bit  no_idle     = 1'b0;
    t_queue_request next_req;

    min_priority_queue DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_action   (i_action),
        .i_item_tag (i_item_tag),
        .i_item_key (i_item_key),
        .o_valid    (o_valid),
        .o_out_tag  (o_out_tag),
        .o_status   (o_status)
    );

    always #1 i_clk = ~i_clk;

    task automatic predict_queue_op(input logic act, input logic [TAG_W-1:0] tag,
                                    input logic [KEY_W-1:0] key);
        t_queue_result res;
        int best;
        res.tag    = TAG_NONE;
        res.status = ST_OK;
        if (act == ACT_INSERT) begin
            if (shadow_fill >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                shadow_tag[shadow_fill] = tag;
                shadow_key[shadow_fill] = key;
                shadow_fill++;
            end
        end else if (shadow_fill == 0) begin
            res.status = ST_EMPTY;
        end else begin
            // newest to oldest, strictly smaller only, so the newest equal key wins
            best = shadow_fill - 1;
            for (int i = shadow_fill - 2; i >= 0; i--) begin
                if ($signed(shadow_key[i]) < $signed(shadow_key[best])) best = i;
            end
            res.tag = shadow_tag[best];
            for (int i = best; i < shadow_fill - 1; i++) begin
                shadow_tag[i] = shadow_tag[i + 1];
                shadow_key[i] = shadow_key[i + 1];
            end
            shadow_fill--;
        end
        expected_results.push_back(res);
    endtask

    task automatic add_request(input logic act, input logic [TAG_W-1:0] tag,
                               input logic [KEY_W-1:0] key, input bit drain);
        t_queue_request req;
        req.act   = act;
        req.tag   = tag;
        req.key   = key;
        req.gap   = no_idle ? 0 : $urandom_range(0, 14);
        req.drain = drain;
        request_queue.push_back(req);
    endtask

    function automatic logic [KEY_W-1:0] random_key(input int mode);
        logic [KEY_W-1:0] k;
        case (mode)
            1: k = KEY_W'($urandom_range(0, 8)) - KEY_W'(4);
            2: begin
                case ($urandom_range(0, 3))
                    0: k = 16'h8000;
                    1: k = 16'h7FFF;
                    2: k = 16'h0000;
                    default: k = 16'hFFFF;
                endcase
            end
            default: k = KEY_W'($urandom);
        endcase
        return k;
    endfunction

    // driver: a new request may go out on the edge that accepts the previous one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_action    <= ACT_INSERT;
            i_item_tag  <= '0;
            i_item_key  <= '0;
            idle_cycles = 0;
        end else begin
            if (start && !busy) begin
                predict_queue_op(i_action, i_item_tag, i_item_key);
                idle_cycles = 0;
            end
            if (!start || !busy) begin
                if (request_queue.size() != 0 && idle_cycles >= request_queue[0].gap &&
                    !(request_queue[0].drain && expected_results.size() != 0)) begin
                    next_req = request_queue.pop_front();
                    start      <= 1'b1;
                    i_action   <= next_req.act;
                    i_item_tag <= next_req.tag;
                    i_item_key <= next_req.key;
                end else begin
                    start <= 1'b0;
                    idle_cycles = idle_cycles + 1;
                end
            end
        end
    end

    // monitor: every strobed result is a transfer and must match the oldest prediction
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: out_tag %h status %0d", o_out_tag, o_status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_tag !== want.tag) begin
                    $error("out_tag mismatch: expected %h actual %h", want.tag, o_out_tag);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d actual %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] fill_keys[CAPACITY];
        logic [TAG_W-1:0] fill_tags[CAPACITY];
        int insert_pct;
        int key_mode;
        fill_keys = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0005,
                      16'h0005, 16'h0005, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h1234,
                      16'h8001, 16'h8000, 16'h4000, 16'hC000};
        fill_tags = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h1234, 16'h0A01,
                      16'h0A02, 16'h0A03, 16'h5A5A, 16'hA5A5, 16'h0F0F, 16'hF0F0,
                      16'h00FF, 16'hFF00, 16'h3333, 16'hCCCC};

        // directed: empty extract, fill to capacity, rejected insert, then serve a few
        add_request(ACT_EXTRACT, 16'h1111, 16'h2222, 1'b0);
        for (int i = 0; i < CAPACITY; i++) begin
            add_request(ACT_INSERT, fill_tags[i], fill_keys[i], 1'b0);
        end
        // would be the minimum if it were stored
        add_request(ACT_INSERT, 16'h5555, 16'h8000, 1'b0);
        for (int i = 0; i < 6; i++) begin
            add_request(ACT_EXTRACT, TAG_W'($urandom), KEY_W'($urandom), 1'b0);
        end

        // random: blocks with their own insert bias, key spread and idling
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 85;
                endcase
                key_mode = $urandom_range(0, 3);
                no_idle  = ($urandom_range(0, 3) == 0);
            end
            add_request(($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_EXTRACT,
                        TAG_W'($urandom), random_key(key_mode),
                        (n == 0) || ($urandom_range(0, 99) == 0));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (request_queue.size() != 0 || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
